// ----- src/smcp_pkg.sv -----
// Shared types, codes and character constants of the serial motor command parser.
package smcp_pkg;

  typedef enum logic [3:0] {
    MSG_NONE    = 4'd0,
    MSG_MAX     = 4'd1,
    MSG_UP      = 4'd2,
    MSG_MIN     = 4'd3,
    MSG_DOWN    = 4'd4,
    MSG_STOP    = 4'd5,
    MSG_REVERSE = 4'd6,
    MSG_REPORT  = 4'd7,
    MSG_ERROR   = 4'd8,
    MSG_BAUD    = 4'd9
  } msg_e;

  typedef enum logic [1:0] {
    PH_SKIP      = 2'd0,
    PH_DIGITS    = 2'd1,
    PH_DONE_NUM  = 2'd2,
    PH_DONE_NONE = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    CFG_MAX_SPEED     = 2'd0,
    CFG_MIN_SPEED     = 2'd1,
    CFG_FALLBACK_BAUD = 2'd2,
    CFG_UNUSED        = 2'd3
  } cfg_e;

  // Number scanner state
  typedef struct packed {
    phase_e      phase;
    logic [31:0] acc;
  } scan_t;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STOP  = 8'h73;
  localparam logic [7:0] CH_REV   = 8'h72;
  localparam logic [7:0] CH_REP   = 8'h70;
  localparam logic [7:0] CH_INIT  = 8'h69;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int unsigned PREFIX_LEN = 5;

  localparam logic [3:0]  SPEED_RST    = 4'd5;
  localparam logic [3:0]  MAX_SPD_RST  = 4'd10;
  localparam logic [3:0]  MIN_SPD_RST  = 4'd1;
  localparam logic [31:0] BAUD_RST     = 32'd115200;
  localparam logic [31:0] FALLBACK_RST = 32'd9600;
  localparam logic [31:0] ACC_SAT_LIM  = 32'd429496729;

  // Characters of the "BAUD=" prefix
  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h42;
      3'd1:    c = 8'h41;
      3'd2:    c = 8'h55;
      3'd3:    c = 8'h44;
      3'd4:    c = 8'h3D;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ----- src/smcp_scan.sv -----
// Decimal number scanner: one byte step of whitespace skip and digit accumulate.
module smcp_scan import smcp_pkg::*; (
  input  scan_t      cur_i,
  input  logic [7:0] byte_i,
  output scan_t      nxt_o
);

  logic        digit;
  logic        blank;
  logic [3:0]  dval;
  logic [31:0] acc_push;
  logic        sat;

  assign digit = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
  assign blank = (byte_i == CH_SPACE) || ((byte_i >= CH_TAB) && (byte_i <= CH_FF));
  assign dval  = 4'(byte_i - CH_ZERO);

  // Saturate at all ones; otherwise acc*10 + digit
  assign sat = (cur_i.acc > ACC_SAT_LIM) || ((cur_i.acc == ACC_SAT_LIM) && (dval > 4'd5));
  assign acc_push = sat ? 32'hFFFF_FFFF
                        : (cur_i.acc << 3) + (cur_i.acc << 1) + 32'(dval);

  always_comb begin
    nxt_o = cur_i;
    unique case (cur_i.phase)
      PH_SKIP: begin
        if (digit) begin
          nxt_o.acc   = acc_push;
          nxt_o.phase = PH_DIGITS;
        end else if (!blank) begin
          nxt_o.phase = PH_DONE_NONE;
        end
      end
      PH_DIGITS: begin
        if (digit) begin
          nxt_o.acc = acc_push;
        end else begin
          nxt_o.phase = PH_DONE_NUM;
        end
      end
      default: begin
        nxt_o = cur_i;
      end
    endcase
  end

endmodule

// ----- src/serial_motor_command_parser.sv -----
// Top level of the serial motor command parser: input stage, command decode, result register.
//
// Usage: each received serial byte enters as one word on the input channel
// (in_valid_i/in_ready_o, rx_byte_i). Every word yields exactly one result word
// on the output channel (out_valid_o/out_ready_i) carrying the message code,
// speed level, direction, baud rate and the baud-changed flag after that byte.
// The configuration channel (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i)
// writes max_speed (0), min_speed (1) and fallback_baud (2); it is always ready
// and other indexes are dropped. Write it only while no word is in flight.
// Throughput: one word per cycle while out_ready_i does not stall the output;
// the input register feeds one pass of decode and number-scan logic into the
// result register, and the parser state updates in the same cycle the result
// register loads.
// Reset: speed 5, clockwise, baud 115200, prefix matcher idle, registers at
// 10 / 1 / 9600; both channels empty.
// Stall: while out_ready_i is low the result holds, the input register keeps
// one more word, and in_ready_o drops only when both are full.
module serial_motor_command_parser import smcp_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  message_code_o,
  output logic [3:0]  speed_level_o,
  output logic        direction_o,
  output logic [31:0] baud_rate_o,
  output logic        baud_changed_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned POS_W = ($clog2(BUFFER_BYTES) > 3) ? $clog2(BUFFER_BYTES) : 3;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(BUFFER_BYTES - 1);
  localparam logic [POS_W-1:0] POS_PFX  = POS_W'(PREFIX_LEN);

  // Configuration
  logic [3:0]  max_speed_q;
  logic [3:0]  min_speed_q;
  logic [31:0] fallback_q;

  // Input stage
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       adv;

  // Parser state
  logic [3:0]       speed_q, speed_d;
  logic             dir_q, dir_d;
  logic [31:0]      baud_q, baud_d;
  logic             collecting_q, collecting_d;
  logic [POS_W-1:0] pos_q, pos_d;
  scan_t            scan_q, scan_d, scan_step;
  logic [31:0]      last_q, last_d;
  msg_e             msg_d;
  logic             changed_d;

  // Result register
  logic        out_valid_q;
  msg_e        msg_q;
  logic [3:0]  speed_out_q;
  logic        dir_out_q;
  logic [31:0] baud_out_q;
  logic        changed_q;

  assign cfg_ready_o = 1'b1;
  assign adv         = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_speed_q <= MAX_SPD_RST;
      min_speed_q <= MIN_SPD_RST;
      fallback_q  <= FALLBACK_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_e'(cfg_index_i))
        CFG_MAX_SPEED:     max_speed_q <= cfg_data_i[3:0];
        CFG_MIN_SPEED:     min_speed_q <= cfg_data_i[3:0];
        CFG_FALLBACK_BAUD: fallback_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_byte_q <= rx_byte_i;
    end
  end

  smcp_scan u_scan (
    .cur_i  (scan_q),
    .byte_i (s1_byte_q),
    .nxt_o  (scan_step)
  );

  always_comb begin
    speed_d      = speed_q;
    dir_d        = dir_q;
    baud_d       = baud_q;
    collecting_d = collecting_q;
    pos_d        = pos_q;
    scan_d       = scan_q;
    last_d       = last_q;
    msg_d        = MSG_NONE;
    changed_d    = 1'b0;
    unique case (s1_byte_q)
      CH_PLUS: begin
        if (speed_q >= max_speed_q) begin
          msg_d = MSG_MAX;
        end else begin
          speed_d = speed_q + 4'd1;
          msg_d   = MSG_UP;
        end
      end
      CH_MINUS: begin
        if ((speed_q <= min_speed_q) || (speed_q == 4'd0)) begin
          msg_d = MSG_MIN;
        end else begin
          speed_d = speed_q - 4'd1;
          msg_d   = MSG_DOWN;
        end
      end
      CH_STOP: begin
        speed_d = 4'd0;
        msg_d   = MSG_STOP;
      end
      CH_REV: begin
        dir_d = !dir_q;
        msg_d = MSG_REVERSE;
      end
      CH_REP: begin
        msg_d = MSG_REPORT;
      end
      CH_INIT: begin
        baud_d    = fallback_q;
        changed_d = 1'b1;
      end
      default: begin
        if (!collecting_q) begin
          if ((pos_q < POS_PFX) && (s1_byte_q == prefix_char(pos_q[2:0]))) begin
            if (pos_q + POS_W'(1) == POS_PFX) begin
              pos_d        = '0;
              collecting_d = 1'b1;
            end else begin
              pos_d = pos_q + POS_W'(1);
            end
          end else begin
            pos_d = '0;
            msg_d = MSG_ERROR;
          end
        end else if (s1_byte_q != CH_CR) begin
          // Drop bytes once the buffer is full
          if (pos_q < POS_LAST) begin
            pos_d  = pos_q + POS_W'(1);
            scan_d = scan_step;
          end
        end else begin
          if ((scan_q.phase == PH_DIGITS) || (scan_q.phase == PH_DONE_NUM)) begin
            last_d = scan_q.acc;
            baud_d = scan_q.acc;
          end else begin
            baud_d = last_q;
          end
          changed_d    = 1'b1;
          msg_d        = MSG_BAUD;
          collecting_d = 1'b0;
          pos_d        = '0;
          scan_d.phase = PH_SKIP;
          scan_d.acc   = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q      <= SPEED_RST;
      dir_q        <= 1'b1;
      baud_q       <= BAUD_RST;
      collecting_q <= 1'b0;
      pos_q        <= '0;
      scan_q.phase <= PH_SKIP;
      scan_q.acc   <= '0;
      last_q       <= '0;
    end else if (adv) begin
      speed_q      <= speed_d;
      dir_q        <= dir_d;
      baud_q       <= baud_d;
      collecting_q <= collecting_d;
      pos_q        <= pos_d;
      scan_q       <= scan_d;
      last_q       <= last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      msg_q       <= msg_d;
      speed_out_q <= speed_d;
      dir_out_q   <= dir_d;
      baud_out_q  <= baud_d;
      changed_q   <= changed_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign message_code_o = msg_q;
  assign speed_level_o  = speed_out_q;
  assign direction_o    = dir_out_q;
  assign baud_rate_o    = baud_out_q;
  assign baud_changed_o = changed_q;

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (collecting_q ? (pos_q <= POS_LAST) : (pos_q < POS_PFX)))
    else $error("parser position out of range");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(speed_q) && $stable(baud_q) && $stable(pos_q) && $stable(scan_q))
    else $error("parser state moved without a word");

  a_cr_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && collecting_q && (s1_byte_q == CH_CR)
    |=> !collecting_q && (scan_q.phase == PH_SKIP) && (scan_q.acc == 32'd0)
        && out_valid_o && (message_code_o == MSG_BAUD) && baud_changed_o)
    else $error("carriage return did not close the baud command");

  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && out_valid_q && !out_ready_i)
    else $error("input stalled without a full pipeline");
`endif

endmodule
